>>> rtl/lat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types, constants and helpers for the live allocation tracker.
// ----------------------------------------------------------------------------
package lat_pkg;

   // Table geometry (SLOTS must be a power of two, 16 .. 2^20)
   localparam int SLOTS = 4096;
   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   // Field widths
   localparam int KEY_W  = 48;
   localparam int SIZE_W = 32;
   localparam int REC_W  = 32;
   localparam int TOT_W  = 48;

   // Mix hash constants
   localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT = 33;

   // Event codes
   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_REALLOC = 2'd1,
      MODE_FREE    = 2'd2,
      MODE_OTHER   = 2'd3
   } mode_type;

   // Control sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_RM_LOOK,
      ST_RM_CMP,
      ST_RF_LOOK,
      ST_RF_CMP,
      ST_RF_HASH,
      ST_CL_LOOK,
      ST_CL_CMP,
      ST_FIN
   } state_type;

   // One table entry as stored in the slot memory
   typedef struct packed {
      logic              used;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
   } slot_entry_type;

   // Linear probe step with wrap
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      next_slot = (i == LAST_SLOT) ? '0 : i + IDX_W'(1);
   endfunction

endpackage : lat_pkg
`default_nettype wire

>>> rtl/lat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lat_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : lat_ram
`default_nettype wire

>>> rtl/lat_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lat_hash
// Multi-cycle 64-bit mix hash; one 32x32 partial product per cycle.
// Gives the home slot of a key on index, flagged by done, after start.
// ----------------------------------------------------------------------------
module lat_hash
   import lat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [KEY_W-1:0] key,
   output logic                  done,
   output logic [IDX_W-1:0]      index
);

   logic             run_ff, run_in;
   logic             sel_ff, sel_in;
   logic [2:0]       ph_ff, ph_in;
   logic [63:0]      opnd_ff, opnd_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      prod_ff, prod_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] index_ff, index_in;

   logic [63:0] konst;
   logic [63:0] key_ext;
   logic [63:0] mix;
   logic [31:0] mul_a, mul_b;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         sel_ff  <= 1'b0;
         ph_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         sel_ff  <= sel_in;
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      opnd_ff  <= opnd_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      index_ff <= index_in;
   end

   // operand select and one partial product
   always_comb begin
      konst   = sel_ff ? MIX_C2 : MIX_C1;
      key_ext = {{(64 - KEY_W){1'b0}}, key};
      mix     = acc_ff ^ (acc_ff >> MIX_SHIFT);
      mul_a   = (ph_ff == 3'd2) ? opnd_ff[63:32] : opnd_ff[31:0];
      mul_b   = (ph_ff == 3'd1) ? konst[63:32] : konst[31:0];
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // phase sequencing: lo*lo, lo*hi, hi*lo, sum, xor-shift
   always_comb begin
      run_in   = run_ff;
      sel_in   = sel_ff;
      ph_in    = ph_ff;
      opnd_in  = opnd_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      index_in = index_ff;
      if (start) begin
         run_in  = 1'b1;
         sel_in  = 1'b0;
         ph_in   = '0;
         opnd_in = key_ext ^ (key_ext >> MIX_SHIFT);
      end else if (run_ff) begin
         ph_in = ph_ff + 3'd1;
         case (ph_ff)
            3'd1: acc_in = prod_ff;
            3'd2: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            3'd3: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            3'd4: begin
               ph_in = '0;
               if (!sel_ff) begin
                  opnd_in = mix;
                  sel_in  = 1'b1;
               end else begin
                  run_in   = 1'b0;
                  done_in  = 1'b1;
                  index_in = mix[IDX_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign done  = done_ff;
   assign index = index_ff;

endmodule : lat_hash
`default_nettype wire

>>> rtl/live_allocation_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// live_allocation_tracker_core
// Replays allocation events against an open-addressed, linearly probed
// address table and keeps live, peak and threshold byte statistics.
// ----------------------------------------------------------------------------
// One event is processed at a time. After reset a clearing pass writes every
// slot empty in turn, during which req_ready is low. An other event passes
// from the request transfer straight to the final update; any other event
// takes the request transfer, the hashing, a look and a compare step per
// probed slot on lookup and insert, and the final update. A free or realloc
// that removes an entry also, for each following entry of its cluster, reads
// it, rehashes it and probes slots to reinsert it.
// The rate is set by the single slot memory read port (a look and a compare
// step per probe) and the shared multi-cycle hash unit. A result waits in an
// output register, and the next request is taken while it waits; that next
// event then holds in its final state until the waiting result has been taken.
module live_allocation_tracker_core
   import lat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [KEY_W-1:0]  req_address,
   input  wire logic [SIZE_W-1:0] req_block_size,
   input  wire logic [REC_W-1:0]  req_record_number,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [TOT_W-1:0]       rsp_live_before,
   output logic [TOT_W-1:0]       rsp_live_after,
   output logic [TOT_W-1:0]       rsp_peak_bytes,
   output logic [REC_W-1:0]       rsp_peak_record,
   output logic                   rsp_crossed,
   output logic [REC_W-1:0]       rsp_cross_record,
   output logic [TOT_W-1:0]       rsp_cross_live,
   output logic                   rsp_old_found,
   output logic [SIZE_W-1:0]      rsp_released_size,
   output logic                   rsp_table_full,
   // threshold register
   input  wire logic              csr_we,
   input  wire logic [TOT_W-1:0]  csr_wdata
);

   // sequencer and event registers
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   mode_type          mode_ff, mode_in;
   logic [KEY_W-1:0]  addr_ff, addr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  rf_idx_ff, rf_idx_in;
   logic [IDX_W-1:0]  rf_cnt_ff, rf_cnt_in;
   logic [KEY_W-1:0]  mv_key_ff, mv_key_in;
   logic [SIZE_W-1:0] mv_size_ff, mv_size_in;
   logic              refill_ff, refill_in;
   logic              found_ff, found_in;
   logic [SIZE_W-1:0] released_ff, released_in;
   logic              full_ff, full_in;
   logic [TOT_W-1:0]  before_ff, before_in;

   // statistics
   logic [TOT_W-1:0]  live_ff, live_in;
   logic [TOT_W-1:0]  peak_ff, peak_in;
   logic [REC_W-1:0]  peak_at_ff, peak_at_in;
   logic              crossed_ff, crossed_in;
   logic [REC_W-1:0]  cross_at_ff, cross_at_in;
   logic [TOT_W-1:0]  cross_total_ff, cross_total_in;
   logic [TOT_W-1:0]  thresh_ff, thresh_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_out;

   // memory and hash interface
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_entry_type    wr_entry;
   logic [IDX_W-1:0]  rd_addr;
   logic [$bits(slot_entry_type)-1:0] rd_raw;
   slot_entry_type    rd_entry;
   logic              hash_start;
   logic [KEY_W-1:0]  hash_key;
   logic              hash_done;
   logic [IDX_W-1:0]  hash_index;

   // working values
   logic [KEY_W-1:0]  cl_key;
   logic [SIZE_W-1:0] cl_size;
   logic [TOT_W:0]    live_sum;
   logic [TOT_W-1:0]  released_ext;
   logic [TOT_W-1:0]  fin_peak;
   logic              fin_peak_up;
   logic              fin_cross;

   lat_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   lat_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .index (hash_index)
   );

   assign rd_entry = slot_entry_type'(rd_raw);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         live_ff        <= '0;
         peak_ff        <= '0;
         peak_at_ff     <= '0;
         crossed_ff     <= 1'b0;
         cross_at_ff    <= '0;
         cross_total_ff <= '0;
         thresh_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         live_ff        <= live_in;
         peak_ff        <= peak_in;
         peak_at_ff     <= peak_at_in;
         crossed_ff     <= crossed_in;
         cross_at_ff    <= cross_at_in;
         cross_total_ff <= cross_total_in;
         thresh_ff      <= thresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // event payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      rec_ff      <= rec_in;
      home_ff     <= home_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      rf_idx_ff   <= rf_idx_in;
      rf_cnt_ff   <= rf_cnt_in;
      mv_key_ff   <= mv_key_in;
      mv_size_ff  <= mv_size_in;
      refill_ff   <= refill_in;
      found_ff    <= found_in;
      released_ff <= released_in;
      full_ff     <= full_in;
      before_ff   <= before_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_live_before   <= before_ff;
         rsp_live_after    <= live_ff;
         rsp_peak_bytes    <= fin_peak;
         rsp_peak_record   <= fin_peak_up ? rec_ff : peak_at_ff;
         rsp_crossed       <= crossed_ff | fin_cross;
         rsp_cross_record  <= fin_cross ? rec_ff : cross_at_ff;
         rsp_cross_live    <= fin_cross ? live_ff : cross_total_ff;
         rsp_old_found     <= found_ff;
         rsp_released_size <= released_ff;
         rsp_table_full    <= full_ff;
      end
   end

   // end-of-event statistics
   always_comb begin
      fin_peak_up  = live_ff > peak_ff;
      fin_peak     = fin_peak_up ? live_ff : peak_ff;
      fin_cross    = (thresh_ff != '0) && !crossed_ff && (live_ff >= thresh_ff);
      cl_key       = refill_ff ? mv_key_ff : addr_ff;
      cl_size      = refill_ff ? mv_size_ff : size_ff;
      live_sum     = {1'b0, live_ff} + (TOT_W + 1)'(size_ff);
      released_ext = TOT_W'(rd_entry.size);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      size_in        = size_ff;
      rec_in         = rec_ff;
      home_in        = home_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      rf_idx_in      = rf_idx_ff;
      rf_cnt_in      = rf_cnt_ff;
      mv_key_in      = mv_key_ff;
      mv_size_in     = mv_size_ff;
      refill_in      = refill_ff;
      found_in       = found_ff;
      released_in    = released_ff;
      full_in        = full_ff;
      before_in      = before_ff;
      live_in        = live_ff;
      peak_in        = peak_ff;
      peak_at_in     = peak_at_ff;
      crossed_in     = crossed_ff;
      cross_at_in    = cross_at_ff;
      cross_total_in = cross_total_ff;
      thresh_in      = csr_we ? csr_wdata : thresh_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      load_out       = 1'b0;
      req_ready      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_entry       = '0;
      rd_addr        = idx_ff;
      hash_start     = 1'b0;
      hash_key       = req_address;

      unique case (state_ff)
         // empty every slot after reset
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in     = mode_type'(req_mode);
               addr_in     = req_address;
               size_in     = req_block_size;
               rec_in      = req_record_number;
               before_in   = live_ff;
               found_in    = 1'b0;
               released_in = '0;
               full_in     = 1'b0;
               refill_in   = 1'b0;
               if (mode_type'(req_mode) == MODE_OTHER) begin
                  state_in = ST_FIN;
               end else begin
                  hash_start = 1'b1;
                  state_in   = ST_HASH;
               end
            end
         end

         ST_HASH: begin
            if (hash_done) begin
               home_in = hash_index;
               idx_in  = hash_index;
               cnt_in  = '0;
               state_in = (mode_ff == MODE_ALLOC) ? ST_CL_LOOK : ST_RM_LOOK;
            end
         end

         ST_RM_LOOK: state_in = ST_RM_CMP;

         // removal lookup
         ST_RM_CMP: begin
            if (rd_entry.used && rd_entry.key == addr_ff) begin
               found_in    = 1'b1;
               released_in = rd_entry.size;
               live_in     = (live_ff >= released_ext) ? live_ff - released_ext : '0;
               wr_en       = 1'b1;
               rf_idx_in   = next_slot(idx_ff);
               rf_cnt_in   = '0;
               state_in    = ST_RF_LOOK;
            end else if (rd_entry.used && cnt_ff != LAST_SLOT) begin
               idx_in   = next_slot(idx_ff);
               cnt_in   = cnt_ff + IDX_W'(1);
               state_in = ST_RM_LOOK;
            end else if (mode_ff == MODE_REALLOC) begin
               idx_in   = home_ff;
               cnt_in   = '0;
               state_in = ST_CL_LOOK;
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_RF_LOOK: begin
            rd_addr  = rf_idx_ff;
            state_in = ST_RF_CMP;
         end

         // take the next cluster entry out and rehash it
         ST_RF_CMP: begin
            if (rd_entry.used && rf_cnt_ff != LAST_SLOT) begin
               mv_key_in  = rd_entry.key;
               mv_size_in = rd_entry.size;
               wr_en      = 1'b1;
               wr_addr    = rf_idx_ff;
               hash_start = 1'b1;
               hash_key   = rd_entry.key;
               refill_in  = 1'b1;
               state_in   = ST_RF_HASH;
            end else if (mode_ff == MODE_REALLOC) begin
               refill_in = 1'b0;
               idx_in    = home_ff;
               cnt_in    = '0;
               state_in  = ST_CL_LOOK;
            end else begin
               refill_in = 1'b0;
               state_in  = ST_FIN;
            end
         end

         ST_RF_HASH: begin
            if (hash_done) begin
               idx_in   = hash_index;
               cnt_in   = '0;
               state_in = ST_CL_LOOK;
            end
         end

         ST_CL_LOOK: state_in = ST_CL_CMP;

         // find the key or claim a free slot
         ST_CL_CMP: begin
            if (!rd_entry.used || rd_entry.key == cl_key) begin
               wr_en    = 1'b1;
               wr_entry = '{used: 1'b1, key: cl_key, size: cl_size};
               if (refill_ff) begin
                  rf_idx_in = next_slot(rf_idx_ff);
                  rf_cnt_in = rf_cnt_ff + IDX_W'(1);
                  state_in  = ST_RF_LOOK;
               end else begin
                  live_in  = live_sum[TOT_W] ? '1 : live_sum[TOT_W-1:0];
                  state_in = ST_FIN;
               end
            end else if (cnt_ff != LAST_SLOT) begin
               idx_in   = next_slot(idx_ff);
               cnt_in   = cnt_ff + IDX_W'(1);
               state_in = ST_CL_LOOK;
            end else if (refill_ff) begin
               rf_idx_in = next_slot(rf_idx_ff);
               rf_cnt_in = rf_cnt_ff + IDX_W'(1);
               state_in  = ST_RF_LOOK;
            end else begin
               full_in  = 1'b1;
               state_in = ST_FIN;
            end
         end

         // statistics update and result transfer
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               peak_in      = fin_peak;
               if (fin_peak_up) begin
                  peak_at_in = rec_ff;
               end
               if (fin_cross) begin
                  crossed_in     = 1'b1;
                  cross_at_in    = rec_ff;
                  cross_total_in = live_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // no request is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request accepted during clearing pass");

   // hash results only arrive while a hash is awaited
   a_hash_expected: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH || state_ff == ST_RF_HASH))
      else $error("unexpected hash completion");

   // peak never trails the live total
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_live_after <= rsp_peak_bytes)
      else $error("peak below live total");

   // a removal frees a slot, so the following insert cannot be dropped
   a_full_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_table_full |-> !rsp_old_found)
      else $error("table full after removal");

   // a released size is only reported with a found entry
   a_released_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_released_size != '0 |-> rsp_old_found)
      else $error("released size without found entry");
`endif

endmodule : live_allocation_tracker_core
`default_nettype wire

>>> bench/live_allocation_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// live_allocation_tracker_core_tb
// Self-checking bench for the live allocation tracker. A scoreboard class keeps
// its own address table and byte statistics, predicts every response and
// checks each response transfer field by field. The stimulus covers directed
// corner cases and random event streams over colliding addresses (cluster
// refill, wrap). The bench runs through several idle/stall mixes and
// threshold settings.
// ----------------------------------------------------------------------------
module live_allocation_tracker_core_tb
   import lat_pkg::*;
;

   localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   // Expected content of one response transfer
   typedef struct {
      logic [TOT_W-1:0]  live_before;
      logic [TOT_W-1:0]  live_after;
      logic [TOT_W-1:0]  peak_bytes;
      logic [REC_W-1:0]  peak_record;
      logic              crossed;
      logic [REC_W-1:0]  cross_record;
      logic [TOT_W-1:0]  cross_live;
      logic              old_found;
      logic [SIZE_W-1:0] released_size;
      logic              table_full;
   } tracker_result_type;

   // Scoreboard: shadow table plus statistics, queue of pending responses
   class tracker_scoreboard;
      bit                 used[SLOTS];
      logic [KEY_W-1:0]   keys[SLOTS];
      logic [SIZE_W-1:0]  sizes[SLOTS];
      logic [TOT_W-1:0]   live, peak, cross_tot, threshold;
      logic [REC_W-1:0]   peak_rec, cross_rec;
      bit                 crossed;
      tracker_result_type pending[$];
      int                 errors;

      function new();
         for (int i = 0; i < SLOTS; i++) used[i] = 0;
         live = '0; peak = '0; cross_tot = '0; threshold = '0;
         peak_rec = '0; cross_rec = '0; crossed = 0; errors = 0;
      endfunction

      function int home_slot(logic [KEY_W-1:0] key);
         logic [63:0] v;
         v = 64'(key);
         v = v ^ (v >> MIX_SHIFT);
         v = v * MIX_C1;
         v = v ^ (v >> MIX_SHIFT);
         v = v * MIX_C2;
         v = v ^ (v >> MIX_SHIFT);
         return int'(v % 64'(SLOTS));
      endfunction

      function int step(int i);
         return (i + 1 >= SLOTS) ? 0 : i + 1;
      endfunction

      // find key or take the first empty slot of its probe run
      function bit claim(logic [KEY_W-1:0] key, output int where);
         int i;
         i = home_slot(key);
         where = 0;
         for (int n = 0; n < SLOTS; n++) begin
            if (!used[i]) begin
               used[i] = 1; keys[i] = key; sizes[i] = '0;
               where = i;
               return 1;
            end
            if (keys[i] == key) begin
               where = i;
               return 1;
            end
            i = step(i);
         end
         return 0;
      endfunction

      // delete key, then pull out and reinsert the rest of its cluster
      function bit remove(logic [KEY_W-1:0] key, output logic [SIZE_W-1:0] got);
         int i, j, dst;
         logic [KEY_W-1:0] mk;
         logic [SIZE_W-1:0] ms;
         i = home_slot(key);
         got = '0;
         for (int n = 0; n < SLOTS; n++) begin
            if (!used[i]) return 0;
            if (keys[i] == key) begin
               got = sizes[i];
               used[i] = 0;
               j = step(i);
               for (int k = 0; k + 1 < SLOTS && used[j]; k++) begin
                  mk = keys[j]; ms = sizes[j];
                  used[j] = 0;
                  if (claim(mk, dst)) sizes[dst] = ms;
                  j = step(j);
               end
               return 1;
            end
            i = step(i);
         end
         return 0;
      endfunction

      function void note_event(mode_type mode, logic [KEY_W-1:0] addr,
                               logic [SIZE_W-1:0] size, logic [REC_W-1:0] rec);
         tracker_result_type r;
         logic [TOT_W:0] sum;
         int where;
         r.live_before = live;
         r.old_found = 0; r.released_size = '0; r.table_full = 0;
         if (mode == MODE_REALLOC || mode == MODE_FREE) begin
            r.old_found = remove(addr, r.released_size);
            if (r.old_found)
               live = (live >= TOT_W'(r.released_size)) ? live - TOT_W'(r.released_size) : '0;
         end
         if (mode == MODE_ALLOC || mode == MODE_REALLOC) begin
            if (claim(addr, where)) begin
               sizes[where] = size;
               sum = {1'b0, live} + (TOT_W + 1)'(size);
               live = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
            end else begin
               r.table_full = 1;
            end
         end
         if (live > peak) begin
            peak = live; peak_rec = rec;
         end
         if (threshold != '0 && !crossed && live >= threshold) begin
            crossed = 1; cross_rec = rec; cross_tot = live;
         end
         r.live_after = live; r.peak_bytes = peak; r.peak_record = peak_rec;
         r.crossed = crossed; r.cross_record = cross_rec; r.cross_live = cross_tot;
         pending.push_back(r);
      endfunction

      function void field(string name, logic [63:0] exp, logic [63:0] act);
         if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_result(tracker_result_type got);
         tracker_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual live_after %0h",
                     $time, got.live_after);
            return;
         end
         e = pending.pop_front();
         field("live_before",   64'(e.live_before),   64'(got.live_before));
         field("live_after",    64'(e.live_after),    64'(got.live_after));
         field("peak_bytes",    64'(e.peak_bytes),    64'(got.peak_bytes));
         field("peak_record",   64'(e.peak_record),   64'(got.peak_record));
         field("crossed",       64'(e.crossed),       64'(got.crossed));
         field("cross_record",  64'(e.cross_record),  64'(got.cross_record));
         field("cross_live",    64'(e.cross_live),    64'(got.cross_live));
         field("old_found",     64'(e.old_found),     64'(got.old_found));
         field("released_size", 64'(e.released_size), 64'(got.released_size));
         field("table_full",    64'(e.table_full),    64'(got.table_full));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_mode;
   logic [KEY_W-1:0]  req_address;
   logic [SIZE_W-1:0] req_block_size;
   logic [REC_W-1:0]  req_record_number;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [TOT_W-1:0]  rsp_live_before;
   logic [TOT_W-1:0]  rsp_live_after;
   logic [TOT_W-1:0]  rsp_peak_bytes;
   logic [REC_W-1:0]  rsp_peak_record;
   logic              rsp_crossed;
   logic [REC_W-1:0]  rsp_cross_record;
   logic [TOT_W-1:0]  rsp_cross_live;
   logic              rsp_old_found;
   logic [SIZE_W-1:0] rsp_released_size;
   logic              rsp_table_full;
   logic              csr_we;
   logic [TOT_W-1:0]  csr_wdata;

   tracker_scoreboard sb = new();

   int               send_idle_pct;
   int               stall_pct;
   int               test_phase;
   logic [REC_W-1:0] rec_count;
   logic [KEY_W-1:0] key_pool[$];

   live_allocation_tracker_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_block_size    (req_block_size),
      .req_record_number (req_record_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_live_before   (rsp_live_before),
      .rsp_live_after    (rsp_live_after),
      .rsp_peak_bytes    (rsp_peak_bytes),
      .rsp_peak_record   (rsp_peak_record),
      .rsp_crossed       (rsp_crossed),
      .rsp_cross_record  (rsp_cross_record),
      .rsp_cross_live    (rsp_cross_live),
      .rsp_old_found     (rsp_old_found),
      .rsp_released_size (rsp_released_size),
      .rsp_table_full    (rsp_table_full),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Run limit
   initial begin
      #300ms;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, one long hold-off in phase 3
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_ready <= 0;
      forever begin
         @(posedge clock);
         if (test_phase == 3 && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Response check on every transfer
   always @(posedge clock) begin
      tracker_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.live_before   = rsp_live_before;
         got.live_after    = rsp_live_after;
         got.peak_bytes    = rsp_peak_bytes;
         got.peak_record   = rsp_peak_record;
         got.crossed       = rsp_crossed;
         got.cross_record  = rsp_cross_record;
         got.cross_live    = rsp_cross_live;
         got.old_found     = rsp_old_found;
         got.released_size = rsp_released_size;
         got.table_full    = rsp_table_full;
         sb.check_result(got);
      end
   end

   // Offer one event and hold it until the request transfer
   task automatic send_event(mode_type mode, logic [KEY_W-1:0] addr,
                             logic [SIZE_W-1:0] size, logic [REC_W-1:0] rec);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid         <= 1;
      req_mode          <= mode;
      req_address       <= addr;
      req_block_size    <= size;
      req_record_number <= rec;
      do @(posedge clock); while (!req_ready);
      sb.note_event(mode, addr, size, rec);
   endtask

   task automatic send_next(mode_type mode, logic [KEY_W-1:0] addr, logic [SIZE_W-1:0] size);
      rec_count++;
      send_event(mode, addr, size, rec_count);
   endtask

   // Stop offering and wait for every pending response
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_threshold(logic [TOT_W-1:0] value);
      csr_we    <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 0;
      sb.threshold = value;
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      return KEY_W'({$urandom(), $urandom()});
   endfunction

   // Random event stream, mostly on the colliding pool
   task automatic random_events(int count);
      int pick;
      logic [KEY_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      mode_type mode;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         mode = (pick < 35) ? MODE_ALLOC : (pick < 55) ? MODE_REALLOC :
                (pick < 90) ? MODE_FREE : MODE_OTHER;
         addr = ($urandom_range(99) < 85) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                          : rand_key();
         pick = $urandom_range(9);
         size = (pick == 0) ? SIZE_MAX : (pick < 3) ? SIZE_W'($urandom_range(255))
                                                    : $urandom();
         if ($urandom_range(19) == 0) send_event(mode, addr, size, $urandom());
         else send_next(mode, addr, size);
      end
   endtask

   // Main sequence
   initial begin
      logic [KEY_W-1:0] addr;
      reset <= 1;
      req_valid <= 0; req_mode <= MODE_OTHER; req_address <= '0;
      req_block_size <= '0; req_record_number <= '0;
      csr_we <= 0; csr_wdata <= '0;
      send_idle_pct = 0; stall_pct = 0; test_phase = 0; rec_count = '0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // pool: keys whose home slots sit around the wrap point, plus plain keys
      while (key_pool.size() < 48) begin
         addr = rand_key();
         if ((sb.home_slot(addr) + 6) % SLOTS < 12) key_pool.push_back(addr);
      end
      repeat (32) key_pool.push_back(rand_key());

      write_threshold('0);

      // Directed: extremes, every mode, present/absent, clusters and refill
      test_phase = 1;
      send_event(MODE_ALLOC, '0, '0, '0);
      send_event(MODE_ALLOC, {KEY_W{1'b1}}, SIZE_MAX, {REC_W{1'b1}});
      send_event(MODE_ALLOC, {KEY_W{1'b1}}, SIZE_W'(5), REC_W'(2));
      send_event(MODE_OTHER, {KEY_W{1'b1}}, SIZE_MAX, REC_W'(3));
      send_event(MODE_REALLOC, '0, SIZE_W'(100), REC_W'(4));
      send_event(MODE_REALLOC, 48'h123456789abc, SIZE_W'(7), REC_W'(5));
      send_event(MODE_FREE, 48'hdeadbeef0000, SIZE_MAX, REC_W'(6));
      send_event(MODE_FREE, {KEY_W{1'b1}}, '0, REC_W'(7));
      for (int i = 0; i < 12; i++)
         send_event(MODE_ALLOC, key_pool[i], SIZE_W'(1000 + i), REC_W'(8 + i));
      send_event(MODE_FREE, key_pool[1], '0, REC_W'(20));
      send_event(MODE_REALLOC, key_pool[4], SIZE_W'(9), REC_W'(21));
      send_event(MODE_FREE, key_pool[0], '0, REC_W'(22));
      send_event(MODE_FREE, key_pool[1], '0, REC_W'(23));
      rec_count = REC_W'(24);

      // Random phases over idle/stall mixes and thresholds
      random_events(300);
      drain();
      write_threshold(TOT_MAX);
      test_phase = 2;
      send_idle_pct = 67; stall_pct = 0;
      random_events(300);
      drain();
      test_phase = 3;
      send_idle_pct = 0; stall_pct = 67;
      random_events(300);
      drain();
      write_threshold(TOT_W'({1'b1, $urandom()}));
      test_phase = 4;
      send_idle_pct = 31; stall_pct = 31;
      random_events(300);
      drain();
      write_threshold(TOT_MAX);
      test_phase = 5;
      send_idle_pct = 0; stall_pct = 0;
      random_events(250);
      drain();
      repeat (50) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
